[sv/wpf_pkg.sv]
// Package for the waypoint follower: types, constants and the CORDIC angle table.
package wpf_pkg;

   localparam int MAX_WAYPOINTS_DEF = 8;
   localparam int CORDIC_STEPS = 16;

   // Operation codes of an input word
   localparam logic OP_POSE = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] REG_KP_LIN = 3'd0;
   localparam logic [2:0] REG_KI_LIN = 3'd1;
   localparam logic [2:0] REG_KD_LIN = 3'd2;
   localparam logic [2:0] REG_KP_ANG = 3'd3;
   localparam logic [2:0] REG_KI_ANG = 3'd4;
   localparam logic [2:0] REG_KD_ANG = 3'd5;
   localparam logic [2:0] REG_THRESH = 3'd6;
   localparam logic [2:0] REG_COUNT  = 3'd7;

   localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;
   localparam logic signed [16:0] BEARING_MAX = 17'sd25736;

   // Work item passed from front to back
   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [15:0] heading;
   } work_type;

   // Gains and threshold as seen by the back end
   typedef struct packed {
      logic signed [15:0] kp_lin;
      logic signed [15:0] ki_lin;
      logic signed [15:0] kd_lin;
      logic signed [15:0] kp_ang;
      logic signed [15:0] ki_ang;
      logic signed [15:0] kd_ang;
      logic [14:0]        thresh;
   } gains_type;

   // Result word
   typedef struct packed {
      logic signed [15:0] lin;
      logic signed [15:0] ang;
      logic               stop;
      logic [3:0]         num;
      logic               last;
   } rsp_type;

   function automatic logic signed [23:0] atan_q20(input logic [3:0] i);
      logic signed [23:0] r;
      unique case (i)
         4'd0: r = 24'sd823550;
         4'd1: r = 24'sd486170;
         4'd2: r = 24'sd256879;
         4'd3: r = 24'sd130396;
         4'd4: r = 24'sd65451;
         4'd5: r = 24'sd32757;
         4'd6: r = 24'sd16383;
         4'd7: r = 24'sd8192;
         4'd8: r = 24'sd4096;
         4'd9: r = 24'sd2048;
         4'd10: r = 24'sd1024;
         4'd11: r = 24'sd512;
         4'd12: r = 24'sd256;
         4'd13: r = 24'sd128;
         4'd14: r = 24'sd64;
         default: r = 24'sd32;
      endcase
      return r;
   endfunction

endpackage

[sv/wpf_front.sv]
// Front end: takes words, keeps the route table and position, forms dx and dy.
module wpf_front #(
   parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF,
   localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic signed [15:0]       req_pos_x,
   input  logic signed [15:0]       req_pos_y,
   input  logic signed [15:0]       req_heading,
   input  logic [2:0]               req_entry_index,
   input  logic signed [15:0]       req_entry_x,
   input  logic signed [15:0]       req_entry_y,
   input  logic [3:0]               count_eff,
   input  logic                     advance,
   output logic                     q_valid,
   input  logic                     q_ready,
   output wpf_pkg::work_type        q_work
);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_READ = 2'b10
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [6:0] pos_ff, pos_in;
   logic signed [15:0] px_ff, py_ff, hd_ff;
   logic [15:0] rd_x, rd_y;
   logic [IW-1:0] wr_addr;
   logic wr_en, hit_slot;
   logic [IW-1:0] rd_addr;
   logic [3:0] rst_cnt_ff;
   logic [15:0] init_x, init_y;
   logic init_active, init_wr;

   // Reset values for slots 0..3 written by a short sweep after reset
   always_comb begin
      unique case (rst_cnt_ff[1:0])
         2'd0: begin init_x = -16'sd7168; init_y = 16'sd2048; end
         2'd1: begin init_x = 16'sd5632; init_y = 16'sd3072; end
         2'd2: begin init_x = 16'sd6656; init_y = -16'sd1229; end
         default: begin init_x = -16'sd6144; init_y = -16'sd3072; end
      endcase
   end
   assign init_active = (rst_cnt_ff < 4'd4);
   // only slots that exist in a small table get a reset value
   assign init_wr = init_active && ({3'd0, rst_cnt_ff} < 7'(MAX_WAYPOINTS));

   always_ff @(posedge clock) begin
      if (reset) rst_cnt_ff <= 4'd0;
      else if (init_active) rst_cnt_ff <= rst_cnt_ff + 4'd1;
   end

   // A word is taken only while the back end is idle, so the route position
   // seen here already includes any advance of the previous pose
   assign hit_slot = ({4'd0, req_entry_index} < 7'(MAX_WAYPOINTS));
   assign req_ready = (state_ff == F_IDLE) && !q_valid && q_ready && !init_active;
   assign wr_en = init_wr || (req_valid && req_ready
                  && req_operation == wpf_pkg::OP_LOAD && hit_slot);
   assign wr_addr = init_active ? IW'(rst_cnt_ff[1:0]) : IW'(req_entry_index);
   assign rd_addr = IW'(pos_ff);

   wpf_ram #(.WIDTH(16), .DEPTH(MAX_WAYPOINTS)) u_xram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(init_active ? init_x : req_entry_x),
      .rd_addr(rd_addr), .rd_data(rd_x));
   wpf_ram #(.WIDTH(16), .DEPTH(MAX_WAYPOINTS)) u_yram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(init_active ? init_y : req_entry_y),
      .rd_addr(rd_addr), .rd_data(rd_y));

   // Pose accepted while route open goes to READ, then into the queue slot
   always_comb begin
      state_in = state_ff;
      pos_in = advance ? pos_ff + 7'd1 : pos_ff;
      unique case (state_ff)
         F_IDLE: if (req_valid && req_ready && req_operation == wpf_pkg::OP_POSE
                     && pos_ff < {3'd0, count_eff}) begin
            state_in = F_READ;
         end
         F_READ: state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_ff <= 7'd0;
         q_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         if (state_ff == F_READ) q_valid <= 1'b1;
         else if (q_ready) q_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         hd_ff <= req_heading;
      end
      if (state_ff == F_READ) begin
         q_work.dx <= 17'(signed'(rd_x)) - 17'(px_ff);
         q_work.dy <= 17'(signed'(rd_y)) - 17'(py_ff);
         q_work.heading <= hd_ff;
      end
   end

endmodule

[sv/wpf_ram.sv]
// Generic single-write, single-read RAM with registered read.
module wpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[sv/wpf_back.sv]
// Back end: square root, CORDIC bearing, two PID channels and result output.
module wpf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  wpf_pkg::work_type     q_work,
   input  wpf_pkg::gains_type    gains,
   input  logic [6:0]            route_num,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wpf_pkg::rsp_type      rsp_word
);

   typedef enum logic [9:0] {
      B_IDLE  = 10'b0000000001,
      B_SQ    = 10'b0000000010,
      B_ITER  = 10'b0000000100,
      B_DIST  = 10'b0000001000,
      B_M0    = 10'b0000010000,
      B_M1    = 10'b0000100000,
      B_M2    = 10'b0001000000,
      B_SUM   = 10'b0010000000,
      B_OUT   = 10'b0100000000,
      B_STOP  = 10'b1000000000
   } bstate_type;

   bstate_type st_ff;
   logic [4:0] it_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic signed [15:0] hd_ff;
   // square root
   logic [33:0] n_ff, r_ff, bit_ff;
   // cordic
   logic signed [31:0] cx_ff, cy_ff;
   logic signed [23:0] cz_ff;
   logic signed [16:0] e_ff;
   logic [15:0] d_ff;
   // PID state
   logic signed [31:0] ilin_ff, iang_ff;
   logic [15:0] pd_ff;
   logic signed [16:0] pe_ff;
   // products and accumulators
   logic signed [49:0] acc_l_ff, acc_a_ff;
   logic signed [49:0] pl_ff, pa_ff;
   logic signed [15:0] lin_ff, ang_ff;
   logic arrive_ff;

   logic signed [31:0] xs, ys;
   logic [33:0] trial;
   logic signed [23:0] zr;
   logic signed [16:0] bear;
   logic signed [17:0] e_wide;
   logic signed [49:0] lin_s, ang_s;
   logic signed [32:0] il_sum, ia_sum;

   assign xs = cx_ff >>> it_ff[3:0];
   assign ys = cy_ff >>> it_ff[3:0];
   assign trial = r_ff + bit_ff;
   assign zr = (cz_ff + 24'sd64) >>> 7;
   assign bear = (dx_ff == 17'sd0 && dy_ff == 17'sd0) ? 17'sd0 :
                 (zr > 24'(wpf_pkg::BEARING_MAX)) ? wpf_pkg::BEARING_MAX :
                 (zr < -24'(wpf_pkg::BEARING_MAX)) ? -wpf_pkg::BEARING_MAX : 17'(zr);
   assign e_wide = 18'(bear) - 18'(hd_ff);
   assign lin_s = acc_l_ff >>> 8;
   assign ang_s = acc_a_ff >>> 11;
   assign il_sum = 33'(ilin_ff) + 33'(signed'({1'b0, d_ff}));
   assign ia_sum = 33'(iang_ff) + 33'(e_ff);

   assign q_ready = (st_ff == B_IDLE);
   assign rsp_valid = (st_ff == B_OUT) || (st_ff == B_STOP);
   assign advance = (st_ff == B_STOP) && rsp_ready;

   always_comb begin
      rsp_word = '0;
      if (st_ff == B_STOP) begin
         rsp_word.stop = 1'b1;
         rsp_word.num = 4'(route_num + 7'd1);
         rsp_word.last = 1'b1;
      end else begin
         rsp_word.lin = lin_ff;
         rsp_word.ang = ang_ff;
         rsp_word.last = !arrive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= B_IDLE;
         ilin_ff <= '0; iang_ff <= '0; pd_ff <= '0; pe_ff <= '0;
      end else begin
         unique case (st_ff)
            B_IDLE: if (q_valid) begin
               dx_ff <= q_work.dx; dy_ff <= q_work.dy; hd_ff <= q_work.heading;
               st_ff <= B_SQ;
            end
            // square the deltas and set up CORDIC pre-rotation
            B_SQ: begin
               n_ff <= 34'(dx_ff * dx_ff) + 34'(dy_ff * dy_ff);
               r_ff <= '0;
               bit_ff <= 34'h1 << 32;
               if (dx_ff < 0) begin
                  if (dy_ff >= 0) begin
                     cx_ff <= 32'(dy_ff) <<< 12; cy_ff <= -(32'(dx_ff) <<< 12);
                     cz_ff <= wpf_pkg::HALF_PI_Q20;
                  end else begin
                     cx_ff <= -(32'(dy_ff) <<< 12); cy_ff <= 32'(dx_ff) <<< 12;
                     cz_ff <= -wpf_pkg::HALF_PI_Q20;
                  end
               end else begin
                  cx_ff <= 32'(dx_ff) <<< 12; cy_ff <= 32'(dy_ff) <<< 12;
                  cz_ff <= '0;
               end
               it_ff <= '0;
               st_ff <= B_ITER;
            end
            // one root digit per cycle, and one CORDIC step in each of those cycles but the last
            B_ITER: begin
               if (n_ff >= trial) begin
                  n_ff <= n_ff - trial;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (it_ff < 5'd16) begin
                  if (cy_ff >= 0) begin
                     cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs;
                     cz_ff <= cz_ff + wpf_pkg::atan_q20(it_ff[3:0]);
                  end else begin
                     cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs;
                     cz_ff <= cz_ff - wpf_pkg::atan_q20(it_ff[3:0]);
                  end
               end
               it_ff <= it_ff + 5'd1;
               if (it_ff == 5'd16) st_ff <= B_DIST;
            end
            B_DIST: begin
               d_ff <= (r_ff > 34'd65535) ? 16'hFFFF : r_ff[15:0];
               e_ff <= 17'(e_wide);
               st_ff <= B_M0;
            end
            // proportional terms, derivative products formed
            B_M0: begin
               acc_l_ff <= 50'(gains.kp_lin * signed'({1'b0, d_ff}));
               acc_a_ff <= 50'(gains.kp_ang * e_ff);
               pl_ff <= 50'(gains.kd_lin * (18'(signed'({1'b0, d_ff}))
                        - 18'(signed'({1'b0, pd_ff}))));
               pa_ff <= 50'(gains.kd_ang * (18'(e_ff) - 18'(pe_ff)));
               st_ff <= B_M1;
            end
            // derivative terms in, integral products formed
            B_M1: begin
               acc_l_ff <= acc_l_ff + pl_ff;
               acc_a_ff <= acc_a_ff + pa_ff;
               pl_ff <= 50'(gains.ki_lin * ilin_ff);
               pa_ff <= 50'(gains.ki_ang * iang_ff);
               st_ff <= B_M2;
            end
            B_M2: begin
               acc_l_ff <= acc_l_ff + pl_ff;
               acc_a_ff <= acc_a_ff + pa_ff;
               st_ff <= B_SUM;
            end
            // cap commands, update integrators
            B_SUM: begin
               lin_ff <= (lin_s > 50'sd1024) ? 16'sd1024 :
                         (lin_s < -50'sd32768) ? -16'sd32768 : 16'(lin_s);
               ang_ff <= (ang_s > 50'sd1024) ? 16'sd1024 :
                         (ang_s < -50'sd32768) ? -16'sd32768 : 16'(ang_s);
               arrive_ff <= (d_ff < {1'b0, gains.thresh});
               if (d_ff < {1'b0, gains.thresh}) begin
                  ilin_ff <= '0; iang_ff <= '0; pd_ff <= '0; pe_ff <= '0;
               end else begin
                  ilin_ff <= (il_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(il_sum);
                  iang_ff <= (ia_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                             (ia_sum < -33'sh0_8000_0000) ? 32'sh8000_0000 : 32'(ia_sum);
                  pd_ff <= d_ff; pe_ff <= e_ff;
               end
               st_ff <= B_OUT;
            end
            B_OUT: if (rsp_ready) st_ff <= arrive_ff ? B_STOP : B_IDLE;
            B_STOP: if (rsp_ready) st_ff <= B_IDLE;
            default: st_ff <= B_IDLE;
         endcase
      end
   end

endmodule

[sv/waypoint_pid_follower_core.sv]
// Top level of the waypoint PID follower: registers, front end and back end.
// A pose word is accepted only while the back end is idle, so each pose runs through
// the 17-step root/CORDIC loop, the three product and accumulate steps and the
// result handshake before the next word is taken.
// Load words are also accepted only once the back end is idle. After reset, slots 0..3
// of the route are filled in a sweep during which no word is accepted.
module waypoint_pid_follower_core #(
   parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   input  logic [2:0]         req_entry_index,
   input  logic signed [15:0] req_entry_x,
   input  logic signed [15:0] req_entry_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_linear_cmd,
   output logic signed [15:0] rsp_angular_cmd,
   output logic               rsp_is_stop,
   output logic [3:0]         rsp_reached_number,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   wpf_pkg::gains_type gains_ff;
   logic [3:0] count_ff, count_eff;
   logic q_valid, q_ready, advance;
   wpf_pkg::work_type q_work;
   wpf_pkg::rsp_type rsp_word;
   logic [6:0] route_num_ff;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '{16'sd256, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 15'd102};
         count_ff <= 4'd4;
      end else if (csr_valid) begin
         unique case (csr_index)
            wpf_pkg::REG_KP_LIN: gains_ff.kp_lin <= csr_data;
            wpf_pkg::REG_KI_LIN: gains_ff.ki_lin <= csr_data;
            wpf_pkg::REG_KD_LIN: gains_ff.kd_lin <= csr_data;
            wpf_pkg::REG_KP_ANG: gains_ff.kp_ang <= csr_data;
            wpf_pkg::REG_KI_ANG: gains_ff.ki_ang <= csr_data;
            wpf_pkg::REG_KD_ANG: gains_ff.kd_ang <= csr_data;
            wpf_pkg::REG_THRESH: gains_ff.thresh <= csr_data[14:0];
            default: count_ff <= csr_data[3:0];
         endcase
      end
   end

   assign count_eff = (8'(count_ff) > 8'(MAX_WAYPOINTS)) ? 4'(MAX_WAYPOINTS) : count_ff;

   // Route position mirror for the stop word number
   always_ff @(posedge clock) begin
      if (reset) route_num_ff <= '0;
      else if (advance) route_num_ff <= route_num_ff + 7'd1;
   end

   wpf_front #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .req_pos_x, .req_pos_y, .req_heading, .req_entry_index,
      .req_entry_x, .req_entry_y, .count_eff, .advance,
      .q_valid, .q_ready, .q_work);

   wpf_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_work, .gains(gains_ff),
      .route_num(route_num_ff), .advance, .rsp_valid, .rsp_ready, .rsp_word);

   assign rsp_linear_cmd = rsp_word.lin;
   assign rsp_angular_cmd = rsp_word.ang;
   assign rsp_is_stop = rsp_word.stop;
   assign rsp_reached_number = rsp_word.num;
   assign rsp_last = rsp_word.last;

endmodule
